// ===== design/bayer_bilinear_demosaic_assert.svh =====
// Assertion macros for the Bayer demosaic block.
// Uses clk and rst_n of the including module; no other dependencies.
`ifndef BAYER_BILINEAR_DEMOSAIC_ASSERT_SVH
`define BAYER_BILINEAR_DEMOSAIC_ASSERT_SVH
`ifndef ASSERT_OFF
`define BBD_ASSERT_IMPL(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed: same-cycle implication");
`define BBD_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed: next-cycle implication");
`else
`define BBD_ASSERT_IMPL(lbl, cond, prop)
`define BBD_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

// ===== design/bbd_pkg.sv =====
// Shared constants and types for the Bayer bilinear demosaic block.
// No dependencies.
package bbd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int MIN_SIZE   = 3;

  localparam logic [PIX_W-1:0]  PIX_MAX        = 8'hFF;
  localparam logic [SIZE_W-1:0] WIDTH_RESET    = SIZE_W'(320);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET   = SIZE_W'(200);
  localparam logic [SIZE_W-1:0] SIZE_MIN       = SIZE_W'(MIN_SIZE);
  localparam logic [SIZE_W-1:0] WIDTH_MAX      = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] HEIGHT_MAX     = SIZE_W'(MAX_HEIGHT);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_HIGHLIGHT    = 2'd2
  } cfg_reg_t;

  // {center row odd, center column odd}
  typedef enum logic [1:0] {
    PH_BLUE    = 2'b00,
    PH_GREEN_B = 2'b01,
    PH_GREEN_R = 2'b10,
    PH_RED     = 2'b11
  } phase_t;

  typedef struct packed {
    logic [PIX_W-1:0] sample;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } stage_t;

endpackage

// ===== design/bayer_bilinear_demosaic.sv =====
// Bayer bilinear demosaic, top level.
// Depends on bbd_pkg, bbd_ram and bayer_bilinear_demosaic_assert.svh.
//
// Usage:
//   in_*  : raw 8-bit Bayer samples in raster order, valid/ready transactions.
//   out_* : one RGB pixel per interior position, (W-2)(H-2) per frame, with
//           end_of_row / end_of_frame flags and the overexposure mark.
//   cfg_* : register writes (0 width, 1 height, 2 highlight), always ready.
//           Writing width or height restarts the frame at the next sample.
// Path: the result for center (x, y) passes the working stage, then the output
//   register, once the transaction carrying sample (x+1, y+1) is accepted.
// Throughput: one sample per cycle while the output is not stalled; the two
//   previous rows sit in one 1024 x 16 RAM, read when a sample is accepted and
//   written back as it leaves the working stage, so each RAM port is used once per sample.
// Reset: width 320, height 200, highlight off, position at row 0 column 0.
//   The line store is not cleared; its stale contents are only read in rows that give no output.
// Stall: a stalled out_ready holds the output register; samples still enter the
//   working stage until one with a result waits; in_ready drops until output moves.
`include "bayer_bilinear_demosaic_assert.svh"
module bayer_bilinear_demosaic
  import bbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     in_raw_sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     out_red,
  output logic [PIX_W-1:0]     out_green,
  output logic [PIX_W-1:0]     out_blue,
  output logic                 out_overexposed_mark,
  output logic                 out_end_of_row,
  output logic                 out_end_of_frame,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  logic [SIZE_W-1:0] frame_width_r, frame_height_r;
  logic              highlight_r;
  logic [SIZE_W-1:0] wd_eff, ht_eff;

  logic [COL_W-1:0]  col_r, col_nxt, col_cur;
  logic [ROW_W-1:0]  row_r, row_nxt, row_cur;
  logic              col_last, row_last;
  logic              cfg_wr, size_wr, in_acc;

  logic              b_vld_r;
  stage_t            b_r;
  logic              b_go, has_res, out_free;

  logic [2*PIX_W-1:0] rd_data;
  logic [PIX_W-1:0]   top, mid;
  logic [PIX_W-1:0]   win_r [6];

  logic [PIX_W+1:0] sum_diag, sum_cross;
  logic [PIX_W:0]   sum_h, sum_v;
  logic [PIX_W-1:0] red_v, green_v, blue_v;
  logic             hit;
  phase_t           phase;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic             out_mark_r, out_eor_r, out_eof_r;

  // configuration
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign size_wr   = cfg_wr && (cfg_reg_t'(cfg_index) == REG_FRAME_WIDTH ||
                                cfg_reg_t'(cfg_index) == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
      highlight_r    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        REG_HIGHLIGHT:    highlight_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width_r < SIZE_MIN) begin
      wd_eff = SIZE_MIN;
    end else if (frame_width_r > WIDTH_MAX) begin
      wd_eff = WIDTH_MAX;
    end else begin
      wd_eff = frame_width_r;
    end
    if (frame_height_r < SIZE_MIN) begin
      ht_eff = SIZE_MIN;
    end else if (frame_height_r > HEIGHT_MAX) begin
      ht_eff = HEIGHT_MAX;
    end else begin
      ht_eff = frame_height_r;
    end
  end

  // input position counters
  assign in_acc = in_valid && in_ready;

  always_comb begin
    col_cur  = (SIZE_W'(col_r) >= wd_eff) ? '0 : col_r;
    row_cur  = (SIZE_W'(row_r) >= ht_eff) ? '0 : row_r;
    col_last = (SIZE_W'(col_cur) == wd_eff - 1'b1);
    row_last = (SIZE_W'(row_cur) == ht_eff - 1'b1);
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (size_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_acc) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_cur + 1'b1;
      end else begin
        col_nxt = col_cur + 1'b1;
        row_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // working stage
  assign out_free = !out_valid_r || out_ready;
  assign has_res  = (b_r.col >= COL_W'(2)) && (b_r.row >= ROW_W'(2));
  assign b_go     = b_vld_r && (!has_res || out_free);
  assign in_ready = !b_vld_r || b_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (in_acc) begin
      b_vld_r <= 1'b1;
    end else if (b_go) begin
      b_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_r <= '{sample: in_raw_sample, col: col_cur, row: row_cur};
    end
  end

  // line stores: upper byte older row, lower byte newer row
  bbd_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (b_go),
    .waddr (b_r.col),
    .wdata ({mid, b_r.sample}),
    .re    (in_acc),
    .raddr (col_cur),
    .rdata (rd_data)
  );

  assign top = rd_data[2*PIX_W-1:PIX_W];
  assign mid = rd_data[PIX_W-1:0];

  // window: 0..2 column x-2 top/mid/bottom, 3..5 column x-1
  always_ff @(posedge clk) begin
    if (b_go) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= b_r.sample;
    end
  end

  // interpolation
  always_comb begin
    sum_diag  = (PIX_W+2)'(win_r[0]) + (PIX_W+2)'(top) + (PIX_W+2)'(win_r[2])
              + (PIX_W+2)'(b_r.sample);
    sum_cross = (PIX_W+2)'(win_r[1]) + (PIX_W+2)'(mid) + (PIX_W+2)'(win_r[5])
              + (PIX_W+2)'(win_r[3]);
    sum_h     = (PIX_W+1)'(win_r[1]) + (PIX_W+1)'(mid);
    sum_v     = (PIX_W+1)'(win_r[3]) + (PIX_W+1)'(win_r[5]);
    // center parity is the opposite of the incoming sample's
    phase     = phase_t'({~b_r.row[0], ~b_r.col[0]});
    unique case (phase)
      PH_RED: begin
        red_v   = win_r[4];
        green_v = sum_cross[PIX_W+1:2];
        blue_v  = sum_diag[PIX_W+1:2];
      end
      PH_GREEN_R: begin
        red_v   = sum_h[PIX_W:1];
        green_v = win_r[4];
        blue_v  = sum_v[PIX_W:1];
      end
      PH_GREEN_B: begin
        red_v   = sum_v[PIX_W:1];
        green_v = win_r[4];
        blue_v  = sum_h[PIX_W:1];
      end
      PH_BLUE: begin
        red_v   = sum_diag[PIX_W+1:2];
        green_v = sum_cross[PIX_W+1:2];
        blue_v  = win_r[4];
      end
      default: begin
        red_v   = '0;
        green_v = '0;
        blue_v  = '0;
      end
    endcase
    hit = highlight_r && (red_v == PIX_MAX || green_v == PIX_MAX || blue_v == PIX_MAX);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_go && has_res) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && has_res) begin
      out_red_r   <= hit ? '0 : red_v;
      out_green_r <= hit ? '0 : green_v;
      out_blue_r  <= hit ? '0 : blue_v;
      out_mark_r  <= hit;
      out_eor_r   <= (SIZE_W'(b_r.col) == wd_eff - 1'b1);
      out_eof_r   <= (SIZE_W'(b_r.col) == wd_eff - 1'b1) &&
                     (SIZE_W'(b_r.row) == ht_eff - 1'b1);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_red              = out_red_r;
  assign out_green            = out_green_r;
  assign out_blue             = out_blue_r;
  assign out_overexposed_mark = out_mark_r;
  assign out_end_of_row       = out_eor_r;
  assign out_end_of_frame     = out_eof_r;

  `BBD_ASSERT_IMPL(a_eof_with_eor, out_valid_r && out_eof_r, out_eor_r)
  `BBD_ASSERT_IMPL(a_mark_is_black, out_valid_r && out_mark_r, (out_red_r == '0) && (out_green_r == '0) && (out_blue_r == '0))
  `BBD_ASSERT_IMPL(a_col_in_range, 1'b1, SIZE_W'(col_r) < wd_eff)
  `BBD_ASSERT_NEXT(a_stage_holds, b_vld_r && !b_go, b_vld_r && $stable(b_r))

endmodule

// ===== design/bbd_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module bbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== tb/sv/bayer_bilinear_demosaic_tb.sv =====
// Testbench for bayer_bilinear_demosaic: streams raw Bayer frames of many sizes
// and checks every RGB pixel against an in-bench bilinear demosaic predictor.
// Depends on bbd_pkg and the bayer_bilinear_demosaic RTL.
module bayer_bilinear_demosaic_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bbd_pkg::*;

  localparam int       HALF_PERIOD = 6;
  localparam int       SETTLE      = 4;
  localparam int       IDLE_PCT    = 14;
  localparam int       CALM_FROM   = 500;
  localparam int       CALM_TO     = 2500;
  localparam int       RAND_ITEMS  = 725;
  localparam int       WIDE_ITEMS  = 40;
  localparam int       TALL_ROWS   = 10;
  localparam int       LIMIT_NS    = 5_000_000;
  localparam int       MAX_PRINTS  = 40;
  localparam cfg_reg_t REG_SPARE   = cfg_reg_t'(2'd3);

  // 4x4 and 4x3 directed frames, first sample in the top byte
  localparam logic [16*PIX_W-1:0] FRAME_4X4 = 128'h00FF01FE_FFFFFF80_FFFFFF07_0003FFFF;
  localparam logic [12*PIX_W-1:0] FRAME_4X3 = 96'hFFFFFFFF_FFFF0AC8_00000000;

  typedef enum logic [1:0] {CMD_SAMPLE, CMD_CFG, CMD_DRAIN} cmd_kind_t;

  typedef struct {
    cmd_kind_t         kind;
    logic [PIX_W-1:0]  sample;
    cfg_reg_t          reg_idx;
    logic [SIZE_W-1:0] data;
  } stim_cmd_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             mark;
    logic             eor;
    logic             eof;
  } rgb_pixel_t;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic [PIX_W-1:0]  in_raw_sample = '0;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic [PIX_W-1:0]  out_red;
  logic [PIX_W-1:0]  out_green;
  logic [PIX_W-1:0]  out_blue;
  logic              out_overexposed_mark;
  logic              out_end_of_row;
  logic              out_end_of_frame;
  logic              cfg_valid     = 1'b0;
  logic              cfg_ready;
  cfg_reg_t          cfg_index     = REG_FRAME_WIDTH;
  logic [SIZE_W-1:0] cfg_data      = '0;

  // predictor state
  logic [PIX_W-1:0]  older_row [MAX_WIDTH];
  logic [PIX_W-1:0]  newer_row [MAX_WIDTH];
  logic [PIX_W-1:0]  win [6]     = '{default: '0};
  int unsigned       col_pos     = 0;
  int unsigned       row_pos     = 0;
  logic [SIZE_W-1:0] width_reg   = WIDTH_RESET;
  logic [SIZE_W-1:0] height_reg  = HEIGHT_RESET;
  logic              highlight_on = 1'b0;

  stim_cmd_t  stim_q [$];
  rgb_pixel_t pixel_q [$];
  int         n_pred        = 0;
  int         pred_total    = 0;
  int         checked_total = 0;
  int         quiet         = 0;
  int         errors        = 0;
  int         cyc           = 0;
  logic       calm;

  assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

  bayer_bilinear_demosaic i_dut (.*);

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) cyc <= cyc + 1;

  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
                                                   logic [SIZE_W-1:0] hi);
    return (v < SIZE_MIN) ? SIZE_MIN : ((v > hi) ? hi : v);
  endfunction

  function automatic void apply_cfg(cfg_reg_t idx, logic [SIZE_W-1:0] d);
    case (idx)
      REG_FRAME_WIDTH: begin
        width_reg = d;
        col_pos   = 0;
        row_pos   = 0;
      end
      REG_FRAME_HEIGHT: begin
        height_reg = d;
        col_pos    = 0;
        row_pos    = 0;
      end
      REG_HIGHLIGHT: highlight_on = d[0];
      default: ;
    endcase
  endfunction

  function automatic bit demosaic_step(input logic [PIX_W-1:0] smp, output rgb_pixel_t px);
    int unsigned      wd, ht, c, r;
    int               ul, ml, ll, um, mm, lm, ur, mr, lr, rd, gr, bl;
    logic [PIX_W-1:0] top, mid;
    phase_t           ph;
    bit               hit;
    wd  = clamp_size(width_reg, WIDTH_MAX);
    ht  = clamp_size(height_reg, HEIGHT_MAX);
    c   = (col_pos >= wd) ? 0 : col_pos;
    r   = (row_pos >= ht) ? 0 : row_pos;
    top = older_row[c];
    mid = newer_row[c];
    older_row[c] = mid;
    newer_row[c] = smp;
    hit = (c >= 2) && (r >= 2);
    px  = '0;
    if (hit) begin
      ul = win[0]; ml = win[1]; ll = win[2];
      um = win[3]; mm = win[4]; lm = win[5];
      ur = top;    mr = mid;    lr = smp;
      // center is one row and one column back, so its parity is inverted
      ph = phase_t'({!r[0], !c[0]});
      case (ph)
        PH_RED: begin
          rd = mm;
          gr = (ml + mr + lm + um) >> 2;
          bl = (ul + ur + ll + lr) >> 2;
        end
        PH_GREEN_R: begin
          rd = (ml + mr) >> 1;
          gr = mm;
          bl = (um + lm) >> 1;
        end
        PH_GREEN_B: begin
          rd = (um + lm) >> 1;
          gr = mm;
          bl = (ml + mr) >> 1;
        end
        default: begin
          rd = (ul + ur + ll + lr) >> 2;
          gr = (ml + mr + lm + um) >> 2;
          bl = mm;
        end
      endcase
      px.mark = highlight_on && (rd == PIX_MAX || gr == PIX_MAX || bl == PIX_MAX);
      if (!px.mark) begin
        px.red   = PIX_W'(rd);
        px.green = PIX_W'(gr);
        px.blue  = PIX_W'(bl);
      end
      px.eor = (c == wd - 1);
      px.eof = (c == wd - 1) && (r == ht - 1);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = smp;
    if (c + 1 >= wd) begin
      col_pos = 0;
      row_pos = (r + 1 >= ht) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
    return hit;
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < MAX_PRINTS) $display("%0t: mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, int idx, logic [PIX_W-1:0] got,
                             logic [PIX_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("pixel %0d %s got %0h want %0h", idx, name, got, want));
  endtask

  task automatic add_sample(logic [PIX_W-1:0] s);
    stim_cmd_t c;
    c.kind    = CMD_SAMPLE;
    c.sample  = s;
    c.reg_idx = REG_FRAME_WIDTH;
    c.data    = '0;
    stim_q.push_back(c);
  endtask

  task automatic add_cfg(cfg_reg_t idx, logic [SIZE_W-1:0] d);
    stim_cmd_t c;
    c.kind    = CMD_CFG;
    c.sample  = '0;
    c.reg_idx = idx;
    c.data    = d;
    stim_q.push_back(c);
  endtask

  task automatic add_drain();
    stim_cmd_t c;
    c.kind    = CMD_DRAIN;
    c.sample  = '0;
    c.reg_idx = REG_FRAME_WIDTH;
    c.data    = '0;
    stim_q.push_back(c);
  endtask

  function automatic logic [PIX_W-1:0] pick_sample();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return PIX_MAX;
    if (roll < 28) return '0;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  // driver: samples and register writes; writes wait until the block is drained
  always @(posedge clk) begin
    rgb_pixel_t px;
    stim_cmd_t  cmd;
    logic       nxt_in_valid, nxt_cfg_valid, hold;
    bit         idle;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (demosaic_step(in_raw_sample, px)) begin
          pixel_q.push_back(px);
          n_pred++;
        end
        quiet = 0;
      end else if (quiet < SETTLE) begin
        quiet++;
      end
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
      hold          = (in_valid && !in_ready) || (cfg_valid && !cfg_ready);
      nxt_in_valid  = hold && in_valid;
      nxt_cfg_valid = hold && cfg_valid;
      idle          = (n_pred == checked_total) && (quiet >= SETTLE);
      if (!hold && stim_q.size() > 0) begin
        cmd = stim_q[0];
        case (cmd.kind)
          CMD_SAMPLE: begin
            if (calm || $urandom_range(0, 99) >= IDLE_PCT) begin
              nxt_in_valid = 1'b1;
              in_raw_sample <= cmd.sample;
              void'(stim_q.pop_front());
            end
          end
          CMD_CFG: begin
            if (idle) begin
              nxt_cfg_valid = 1'b1;
              cfg_index <= cmd.reg_idx;
              cfg_data  <= cmd.data;
              void'(stim_q.pop_front());
            end
          end
          default: begin
            if (idle) void'(stim_q.pop_front());
          end
        endcase
      end
      in_valid   <= nxt_in_valid;
      cfg_valid  <= nxt_cfg_valid;
      pred_total <= n_pred;
    end
  end

  // monitor: each pixel transaction against the oldest prediction
  always @(posedge clk) begin
    rgb_pixel_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (checked_total == pred_total) begin
          report_mismatch($sformatf("unpredicted pixel r=%0h g=%0h b=%0h",
                                    out_red, out_green, out_blue));
        end else begin
          want = pixel_q.pop_front();
          check_field("red", checked_total, out_red, want.red);
          check_field("green", checked_total, out_green, want.green);
          check_field("blue", checked_total, out_blue, want.blue);
          check_field("overexposed_mark", checked_total, out_overexposed_mark, want.mark);
          check_field("end_of_row", checked_total, out_end_of_row, want.eor);
          check_field("end_of_frame", checked_total, out_end_of_frame, want.eof);
          checked_total <= checked_total + 1;
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    int unsigned rand_items, gen_w, gen_h, frame_len, n, drain_at, kind, roll;
    logic [SIZE_W-1:0] wv, hv;

    // directed: all four color phases, saturated sums, highlight off then on
    add_cfg(REG_FRAME_WIDTH, SIZE_W'(4));
    for (int i = 0; i < 16; i++) add_sample(FRAME_4X4[PIX_W*(15-i) +: PIX_W]);
    add_cfg(REG_HIGHLIGHT, 11'h7FF);
    add_cfg(REG_FRAME_HEIGHT, SIZE_W'(3));
    for (int i = 0; i < 12; i++) add_sample(FRAME_4X3[PIX_W*(11-i) +: PIX_W]);

    // sizes below the minimum, then an unused index written mid-frame
    add_cfg(REG_FRAME_WIDTH, '0);
    add_cfg(REG_FRAME_HEIGHT, SIZE_W'(1));
    add_cfg(REG_HIGHLIGHT, 11'h7FE);
    for (int i = 0; i < 20; i++) add_sample(pick_sample());
    add_cfg(REG_SPARE, 11'h7FF);
    for (int i = 0; i < 7; i++) add_sample(pick_sample());

    // sizes above the maximum: a burst into a wide row, then a tall frame
    add_cfg(REG_FRAME_WIDTH, 11'h7FF);
    add_cfg(REG_FRAME_HEIGHT, SIZE_W'(3));
    add_cfg(REG_HIGHLIGHT, SIZE_W'($urandom_range(0, 2047)));
    for (int i = 0; i < WIDE_ITEMS; i++) add_sample(pick_sample());
    add_cfg(REG_FRAME_WIDTH, SIZE_W'(3));
    add_cfg(REG_FRAME_HEIGHT, 11'h7FF);
    for (int i = 0; i < 3 * TALL_ROWS; i++) add_sample(pick_sample());

    // random phases: mostly whole small frames, some cut short
    gen_w      = 3;
    gen_h      = MAX_HEIGHT;
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        roll = $urandom_range(0, 9);
        wv = (roll < 7) ? SIZE_W'($urandom_range(3, 12)) :
             (roll < 9) ? SIZE_W'($urandom_range(13, 64)) : SIZE_W'($urandom_range(0, 2));
        hv = ($urandom_range(0, 9) < 8) ? SIZE_W'($urandom_range(3, 8)) :
                                         SIZE_W'($urandom_range(0, 2));
        add_cfg(REG_FRAME_WIDTH, wv);
        add_cfg(REG_FRAME_HEIGHT, hv);
        gen_w = clamp_size(wv, WIDTH_MAX);
        gen_h = clamp_size(hv, HEIGHT_MAX);
        if ($urandom_range(0, 1) == 1)
          add_cfg(REG_HIGHLIGHT, SIZE_W'($urandom_range(0, 2047)));
      end else if (kind < 9) begin
        add_cfg(REG_HIGHLIGHT, SIZE_W'($urandom_range(0, 2047)));
      end else begin
        add_drain();
      end
      frame_len = gen_w * gen_h;
      if (frame_len > 600) n = $urandom_range(10, 60);
      else begin
        n = $urandom_range(1, 2) * frame_len;
        if ($urandom_range(0, 2) == 0) n += $urandom_range(0, frame_len - 1);
      end
      if (n > RAND_ITEMS - rand_items) n = RAND_ITEMS - rand_items;
      drain_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : n;
      for (int i = 0; i < n; i++) begin
        add_sample(pick_sample());
        if (i == drain_at) add_drain();
      end
      rand_items += n;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (stim_q.size() != 0 || in_valid || cfg_valid || checked_total != pred_total);
    repeat (4 * SETTLE) @(negedge clk);
    if (pixel_q.size() != 0)
      report_mismatch($sformatf("%0d predicted pixels never came out", pixel_q.size()));
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #LIMIT_NS;
    $display("timeout after %0d ns", LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
